/* rtl/cfa_pkg.sv */
// cfa_pkg: shared types and constants for the contiguous fit allocator.
// No dependencies; imported by cfa_scan and contiguous_fit_allocator.
package cfa_pkg;

	localparam int OWNER_W  = 8;
	localparam int SIZE_W   = 8;
	localparam int START_W  = 7;
	localparam int POLICY_W = 2;

	// placement rule codes; the remaining code denies every request
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	typedef struct packed {
		logic clear;
		logic step;
		logic last;
	} scan_ctl_t;

endpackage

/* rtl/contiguous_fit_allocator.sv */
// contiguous_fit_allocator: top level, sequencer, config register and result register.
// Depends on cfa_pkg, cfa_map and cfa_scan.
// Each request takes a rating pass over all units, then a marking pass, both driven
// by the one-unit-per-cycle map rotation; in_stall holds off the next request until
// the result has been written to the result register.
// A finished result waits in its register while the next request is taken.
// Reset: map all free, fit_policy first fit, no result pending.
module contiguous_fit_allocator #(
	parameter int NUM_UNITS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cfa_pkg::OWNER_W-1:0]   owner_id,
	input  logic [cfa_pkg::SIZE_W-1:0]    request_size,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic [cfa_pkg::START_W-1:0]   start_unit,
	output logic [cfa_pkg::OWNER_W-1:0]   result_owner,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfa_pkg::POLICY_W-1:0]  cfg_data
);
	import cfa_pkg::*;

	localparam int POS_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int CNT_W = $clog2(NUM_UNITS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_MARK, ST_DONE} state_t;

	state_t               state_q;
	logic [POS_W-1:0]     pos_q;
	logic [SIZE_W-1:0]    size_q;
	logic [SIZE_W-1:0]    left_q;
	logic [OWNER_W-1:0]   owner_q;
	logic [POLICY_W-1:0]  policy_q;
	logic                 out_valid_q;
	logic                 granted_q;
	logic [START_W-1:0]   start_q;
	logic [OWNER_W-1:0]   result_owner_q;

	scan_ctl_t            scan_ctl;
	logic                 head_used;
	logic                 found;
	logic [POS_W-1:0]     pick_start;
	logic                 last;
	logic                 grant_ok;
	logic                 set_bit;
	logic                 accept;
	logic                 out_busy;

	assign last     = pos_q == POS_W'(NUM_UNITS - 1);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_busy = out_valid_q && out_stall;
	assign grant_ok = found && (size_q != '0) &&
		(policy_q == POL_FIRST || policy_q == POL_BEST || policy_q == POL_WORST);
	assign set_bit  = (state_q == ST_MARK) && grant_ok && (pos_q >= pick_start) &&
		(left_q != '0);

	assign scan_ctl.clear = accept;
	assign scan_ctl.step  = state_q == ST_SCAN;
	assign scan_ctl.last  = last;

	cfa_map #(
		.NUM_UNITS(NUM_UNITS)
	) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en ((state_q == ST_SCAN) || (state_q == ST_MARK)),
		.set_bit  (set_bit),
		.head_used(head_used)
	);

	cfa_scan #(
		.NUM_UNITS(NUM_UNITS),
		.POS_W    (POS_W),
		.CNT_W    (CNT_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.unit_used (head_used),
		.pos       (pos_q),
		.policy    (policy_q),
		.size      (size_q),
		.found     (found),
		.pick_start(pick_start)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
		end else if (cfg_valid) begin
			policy_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			owner_q <= owner_id;
			size_q  <= request_size;
			left_q  <= request_size;
		end else if (set_bit) begin
			left_q  <= left_q - SIZE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			pos_q          <= '0;
			out_valid_q    <= 1'b0;
			granted_q      <= 1'b0;
			start_q        <= '0;
			result_owner_q <= '0;
		end else begin
			if (state_q == ST_DONE && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pos_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN, ST_MARK: begin
					if (last) begin
						pos_q   <= '0;
						state_q <= (state_q == ST_SCAN) ? ST_MARK : ST_DONE;
					end else begin
						pos_q   <= pos_q + POS_W'(1);
					end
				end
				ST_DONE: begin
					if (!out_busy) begin
						granted_q      <= grant_ok;
						start_q        <= grant_ok ? START_W'(pick_start) : '0;
						result_owner_q <= owner_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = state_q != ST_IDLE;
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign start_unit   = start_q;
	assign result_owner = result_owner_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && grant_ok) |-> (size_q != '0 && left_q == '0))
		else $error("granted span not fully marked");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_busy) |=> (state_q == ST_DONE && $stable(granted_q)))
		else $error("pending result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pos_q == '0 || $past(!arst_n)) )
		else $error("unit counter not rewound");

endmodule

/* rtl/cfa_map.sv */
// cfa_map: occupancy map held as a rotating shift register, one unit per cycle while shift_en is high.
// No package dependency.
module cfa_map #(
	parameter int NUM_UNITS = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  logic set_bit,
	output logic head_used
);

	logic [NUM_UNITS-1:0] map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (shift_en) begin
			map_q <= {map_q[0] | set_bit, map_q[NUM_UNITS-1:1]};
		end
	end

	assign head_used = map_q[0];

endmodule

/* rtl/cfa_scan.sv */
// cfa_scan: bit-serial hole tracker and placement choice.
// Depends on cfa_pkg.
module cfa_scan #(
	parameter int NUM_UNITS = 128,
	parameter int POS_W     = 7,
	parameter int CNT_W     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfa_pkg::scan_ctl_t            ctl,
	input  logic                          unit_used,
	input  logic [POS_W-1:0]              pos,
	input  logic [cfa_pkg::POLICY_W-1:0]  policy,
	input  logic [cfa_pkg::SIZE_W-1:0]    size,
	output logic                          found,
	output logic [POS_W-1:0]              pick_start
);
	import cfa_pkg::*;

	localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

	logic [POS_W-1:0] run_start_q;
	logic [CNT_W-1:0] run_len_q;
	logic [CNT_W-1:0] pick_len_q;
	logic [POS_W-1:0] pick_start_q;
	logic             found_q;

	logic [POS_W-1:0] next_start;
	logic [CNT_W-1:0] grown_len;
	logic [POS_W-1:0] eval_start;
	logic [CNT_W-1:0] eval_len;
	logic             eval_en;
	logic             fits;
	logic             take;

	always_comb begin
		grown_len  = run_len_q + CNT_W'(1);
		next_start = (run_len_q == '0) ? pos : run_start_q;
		eval_start = unit_used ? run_start_q : next_start;
		eval_len   = unit_used ? run_len_q : grown_len;
		eval_en    = ctl.step && ((unit_used && run_len_q != '0) || (ctl.last && !unit_used));
		fits       = CMP_W'(eval_len) >= CMP_W'(size);
		take       = eval_en && fits &&
			(!found_q ||
			 (policy == POL_BEST  && eval_len < pick_len_q) ||
			 (policy == POL_WORST && eval_len > pick_len_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q <= '0;
			found_q   <= 1'b0;
		end else if (ctl.clear) begin
			run_len_q <= '0;
			found_q   <= 1'b0;
		end else if (ctl.step) begin
			run_len_q <= unit_used ? '0 : grown_len;
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			run_start_q <= next_start;
			if (take) begin
				pick_start_q <= eval_start;
				pick_len_q   <= eval_len;
			end
		end
	end

	assign found      = found_q;
	assign pick_start = pick_start_q;

	// a chosen hole always holds the request
	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (CMP_W'(pick_len_q) >= CMP_W'($past(size)) && found_q))
		else $error("chosen hole shorter than request");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (CNT_W'(run_len_q) <= CNT_W'(NUM_UNITS)))
		else $error("run length beyond map");

endmodule

/* verif/cfa_alloc_checker.sv */
// cfa_alloc_checker: watches the request, result and policy channels of the allocator,
// keeps its own unit map and placement rule, and compares each result in order.
// Depends on cfa_pkg; instantiated by contiguous_fit_allocator_test.
`timescale 1ns / 100ps
module cfa_alloc_checker #(
	parameter int UNITS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [cfa_pkg::OWNER_W-1:0]   owner_id,
	input  logic [cfa_pkg::SIZE_W-1:0]    request_size,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          granted,
	input  logic [cfa_pkg::START_W-1:0]   start_unit,
	input  logic [cfa_pkg::OWNER_W-1:0]   result_owner,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [cfa_pkg::POLICY_W-1:0]  cfg_data,
	output int                            fail_count,
	output int                            awaiting,
	output int                            placed_count,
	output int                            refused_count
);

	typedef struct packed {
		logic                         granted;
		logic [cfa_pkg::START_W-1:0]  start;
		logic [cfa_pkg::OWNER_W-1:0]  owner;
	} alloc_result_t;

	bit [UNITS-1:0]               used_map;
	logic [cfa_pkg::POLICY_W-1:0] fit_policy;
	alloc_result_t                expected_allocs[$];
	alloc_result_t                want;
	int                           errors = 0;
	int                           n_placed = 0;
	int                           n_refused = 0;

	assign fail_count    = errors;
	assign placed_count  = n_placed;
	assign refused_count = n_refused;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
		errors++;
	endtask

	// scans the free runs, picks one by the current rule and claims it
	function automatic alloc_result_t place_request(input logic [cfa_pkg::OWNER_W-1:0] owner,
			input logic [cfa_pkg::SIZE_W-1:0] size);
		alloc_result_t r;
		int run_start, run_len, pick, pick_len, u;
		bit found, take, in_run;
		r.granted = 1'b0;
		r.start   = '0;
		r.owner   = owner;
		found     = 1'b0;
		in_run    = 1'b0;
		run_start = 0;
		pick      = 0;
		pick_len  = 0;
		if (size != 0 && (fit_policy == cfa_pkg::POL_FIRST || fit_policy == cfa_pkg::POL_BEST
				|| fit_policy == cfa_pkg::POL_WORST)) begin
			for (u = 0; u <= UNITS; u++) begin
				if (u < UNITS && !used_map[u]) begin
					if (!in_run) begin
						in_run    = 1'b1;
						run_start = u;
					end
				end else if (in_run) begin
					in_run  = 1'b0;
					run_len = u - run_start;
					take = run_len >= int'(size) && (!found
						|| (fit_policy == cfa_pkg::POL_BEST && run_len < pick_len)
						|| (fit_policy == cfa_pkg::POL_WORST && run_len > pick_len));
					if (take) begin
						found    = 1'b1;
						pick     = run_start;
						pick_len = run_len;
					end
				end
			end
		end
		if (found) begin
			for (u = pick; u < pick + int'(size); u++)
				used_map[u] = 1'b1;
			r.granted = 1'b1;
			r.start   = pick[cfa_pkg::START_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_map   = '0;
			fit_policy = cfa_pkg::POL_FIRST;
			expected_allocs.delete();
			awaiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				fit_policy = cfg_data;
			if (out_valid && !out_stall) begin
				if (expected_allocs.size() == 0) begin
					report_mismatch("result with no request pending, owner",
						int'(result_owner), -1);
				end else begin
					want = expected_allocs.pop_front();
					if (granted !== want.granted)
						report_mismatch("granted", int'(granted), int'(want.granted));
					if (start_unit !== want.start)
						report_mismatch("start_unit", int'(start_unit), int'(want.start));
					if (result_owner !== want.owner)
						report_mismatch("result_owner", int'(result_owner),
							int'(want.owner));
				end
			end
			if (in_valid && !in_stall) begin
				want = place_request(owner_id, request_size);
				if (want.granted)
					n_placed++;
				else
					n_refused++;
				expected_allocs.push_back(want);
			end
			awaiting <= expected_allocs.size();
		end
	end

endmodule

/* verif/contiguous_fit_allocator_test.sv */
// contiguous_fit_allocator_test: clock, reset, request and policy stimulus, random
// stalls, watchdog and verdict. Depends on cfa_pkg, the allocator RTL and cfa_alloc_checker.
`timescale 1ns / 100ps
module contiguous_fit_allocator_test;

	localparam int UNITS      = 128;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 74;
	// reserved rule code: every request refused
	localparam logic [cfa_pkg::POLICY_W-1:0] POL_NONE = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [cfa_pkg::OWNER_W-1:0]   owner_id = '0;
	logic [cfa_pkg::SIZE_W-1:0]    request_size = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          granted;
	logic [cfa_pkg::START_W-1:0]   start_unit;
	logic [cfa_pkg::OWNER_W-1:0]   result_owner;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [cfa_pkg::POLICY_W-1:0]  cfg_data = '0;

	int fail_count, awaiting, placed_count, refused_count;
	int quiet_cycles = 0;
	int sent = 0;
	bit calm = 1'b0;

	always #10 clk = ~clk;

	contiguous_fit_allocator #(.NUM_UNITS(UNITS)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.owner_id(owner_id), .request_size(request_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted(granted), .start_unit(start_unit), .result_owner(result_owner),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	cfa_alloc_checker #(.UNITS(UNITS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.owner_id(owner_id), .request_size(request_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted(granted), .start_unit(start_unit), .result_owner(result_owner),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .awaiting(awaiting),
		.placed_count(placed_count), .refused_count(refused_count)
	);

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 19);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_request(input int owner, input int size);
		if (!calm && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 520)) @(posedge clk);
		end
		owner_id     <= owner[cfa_pkg::OWNER_W-1:0];
		request_size <= size[cfa_pkg::SIZE_W-1:0];
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	// only written once every result is back
	task automatic set_policy(input logic [cfa_pkg::POLICY_W-1:0] pol);
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		cfg_data  <= pol;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int random_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 0;
		else if (r < 60)
			return $urandom_range(1, 3);
		else if (r < 80)
			return $urandom_range(4, 16);
		return $urandom_range(17, 255);
	endfunction

	initial begin
		int phase, k;
		logic [cfa_pkg::POLICY_W-1:0] pol;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_policy(cfa_pkg::POL_FIRST);
		send_request(0, 0);
		send_request(255, 255);
		send_request(1, 129);
		send_request(2, 1);
		send_request(3, 5);
		send_request(4, 128);
		send_request(5, 123);
		set_policy(cfa_pkg::POL_BEST);
		send_request(6, 3);
		send_request(7, 0);
		send_request(128, 7);
		set_policy(cfa_pkg::POL_WORST);
		send_request(8, 4);
		send_request(9, 200);
		send_request(127, 2);
		set_policy(POL_NONE);
		send_request(10, 1);
		send_request(11, 0);
		set_policy(cfa_pkg::POL_FIRST);
		send_request(12, 2);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: pol = cfa_pkg::POL_FIRST;
				1: pol = cfa_pkg::POL_BEST;
				2: pol = cfa_pkg::POL_WORST;
				default: pol = POL_NONE;
			endcase
			if (phase >= 4)
				pol = 2'($urandom_range(0, 3));
			set_policy(pol);
			calm = (phase == 5 || phase == 6);
			for (k = 0; k < PHASE_LEN; k++)
				send_request($urandom_range(0, 255), random_size());
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (2 * UNITS + 40) @(posedge clk);

		$display("%0d requests under first, best, worst and reserved rules", sent);
		$display("%0d spans placed, %0d refused", placed_count, refused_count);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* contiguous_fit_allocator.f */
rtl/cfa_pkg.sv
rtl/cfa_map.sv
rtl/cfa_scan.sv
rtl/contiguous_fit_allocator.sv
verif/cfa_alloc_checker.sv
verif/contiguous_fit_allocator_test.sv
